@@ sv/slf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slf_pkg
// types, register indexes and reset values for the scanline lane span fill
// ----------------------------------------------------------------------------
package slf_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 12;
    localparam int ROW_WIDTH_W   = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_RED   = 3'd0,
        CFG_LINE_GREEN = 3'd1,
        CFG_LINE_BLUE  = 3'd2,
        CFG_LANE_RED   = 3'd3,
        CFG_LANE_GREEN = 3'd4,
        CFG_LANE_BLUE  = 3'd5,
        CFG_ROW_WIDTH  = 3'd6
    } t_cfg_idx;

    localparam logic [7:0]             RST_LINE_RED   = 8'd255;
    localparam logic [7:0]             RST_LINE_GREEN = 8'd0;
    localparam logic [7:0]             RST_LINE_BLUE  = 8'd0;
    localparam logic [7:0]             RST_LANE_RED   = 8'd0;
    localparam logic [7:0]             RST_LANE_GREEN = 8'd255;
    localparam logic [7:0]             RST_LANE_BLUE  = 8'd0;
    localparam logic [ROW_WIDTH_W-1:0] RST_ROW_WIDTH  = 12'd1280;

    typedef struct packed {
        logic [7:0]             line_red;
        logic [7:0]             line_green;
        logic [7:0]             line_blue;
        logic [7:0]             lane_red;
        logic [7:0]             lane_green;
        logic [7:0]             lane_blue;
        logic [ROW_WIDTH_W-1:0] row_width;
    } t_cfg;

    typedef struct packed {
        logic [7:0] overlay_red;
        logic [7:0] overlay_green;
        logic [7:0] overlay_blue;
        logic [7:0] source_red;
        logic [7:0] source_green;
        logic [7:0] source_blue;
        logic       drain;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       out_valid;
        logic       out_end_of_row;
    } t_out_beat;

endpackage

@@ sv/slf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slf_ram
// generic single-write, single-read ram with registered read (read-first)
// ----------------------------------------------------------------------------
module slf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/slf_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slf_cfg_regs
// configuration register file: marker colour, lane colour, row width
// ----------------------------------------------------------------------------
module slf_cfg_regs import slf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LINE_RED:   n_cfg.line_red   = i_cfg_data[7:0];
                CFG_LINE_GREEN: n_cfg.line_green = i_cfg_data[7:0];
                CFG_LINE_BLUE:  n_cfg.line_blue  = i_cfg_data[7:0];
                CFG_LANE_RED:   n_cfg.lane_red   = i_cfg_data[7:0];
                CFG_LANE_GREEN: n_cfg.lane_green = i_cfg_data[7:0];
                CFG_LANE_BLUE:  n_cfg.lane_blue  = i_cfg_data[7:0];
                CFG_ROW_WIDTH:  n_cfg.row_width  = i_cfg_data[ROW_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_red   <= RST_LINE_RED;
            r_cfg.line_green <= RST_LINE_GREEN;
            r_cfg.line_blue  <= RST_LINE_BLUE;
            r_cfg.lane_red   <= RST_LANE_RED;
            r_cfg.lane_green <= RST_LANE_GREEN;
            r_cfg.lane_blue  <= RST_LANE_BLUE;
            r_cfg.row_width  <= RST_ROW_WIDTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/scanline_lane_span_fill.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_lane_span_fill
// marks line-colour pixels per row and fills the span between marker runs
// with the lane colour, emitting the previous row through a row buffer
// ----------------------------------------------------------------------------
// usage:
//   input beats (i_in_valid / o_in_ready) carry overlay and source colours
//   plus a drain flag; drain beats only advance the column and flush.
//   every accepted beat yields exactly one output beat (o_out_valid /
//   i_out_ready): the previous row's pixel at the same column, lane colour
//   inside that row's span, zero colour while no earlier row is buffered.
//   configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
//   marker colour, lane colour and row width; write them while idle.
//   an output beat passes the row buffer read stage, then the output
//   register. throughput: one beat per cycle while the receiver does not
//   stall, set by the single row buffer port pair.
//   reset clears the column, span tracking and pipeline; buffer contents
//   are left as they are. when the receiver stalls, the read stage and the
//   output register hold and input acceptance stops once both are full.
// ----------------------------------------------------------------------------
module scanline_lane_span_fill import slf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W;

    t_cfg cfg;

    slf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // row tracking state
    logic [CW-1:0] r_column, n_column;
    logic          r_in_run, n_in_run;
    logic [CW-1:0] r_start_now, n_start_now;
    logic [CW-1:0] r_stop_now, n_stop_now;
    logic [CW-1:0] r_start_prev, n_start_prev;
    logic [CW-1:0] r_stop_prev, n_stop_prev;
    logic          r_prev_valid, n_prev_valid;
    logic          r_row_pixels, n_row_pixels;

    // read stage and output register
    logic      r_s1_valid;
    logic      r_s1_pv;
    logic      r_s1_span;
    logic      r_s1_last;
    logic      r_out_valid;
    t_out_beat r_out;
    t_out_beat n_out;

    logic          in_acc;
    logic          s1_adv;
    logic [EW-1:0] rw_ext;
    logic [EW-1:0] eff_width;
    logic [EW-1:0] last_col;
    logic          last;
    logic          marked;
    logic          in_span;
    logic [23:0]   rd_pix;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        rw_ext = EW'(cfg.row_width);
        if (rw_ext == '0) begin
            eff_width = EW'(1);
        end else if (rw_ext > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else begin
            eff_width = rw_ext;
        end
        last_col = eff_width - EW'(1);
        last     = EW'(r_column) >= last_col;
    end

    assign marked = (i_in_data.overlay_red   == cfg.line_red)
                 && (i_in_data.overlay_green == cfg.line_green)
                 && (i_in_data.overlay_blue  == cfg.line_blue);

    assign in_span = r_prev_valid && (r_start_prev != '0) && (r_stop_prev != '0)
                  && (r_column >= r_start_prev) && (r_column < r_stop_prev);

    slf_ram #(
        .WIDTH (24),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && !i_in_data.drain),
        .i_waddr (r_column),
        .i_wdata ({i_in_data.source_red, i_in_data.source_green, i_in_data.source_blue}),
        .i_re    (in_acc),
        .i_raddr (r_column),
        .o_rdata (rd_pix)
    );

    always_comb begin
        n_column     = r_column;
        n_in_run     = r_in_run;
        n_start_now  = r_start_now;
        n_stop_now   = r_stop_now;
        n_start_prev = r_start_prev;
        n_stop_prev  = r_stop_prev;
        n_prev_valid = r_prev_valid;
        n_row_pixels = r_row_pixels;
        if (in_acc) begin
            if (!i_in_data.drain) begin
                n_row_pixels = 1'b1;
                if (marked) begin
                    n_in_run = 1'b1;
                    if (r_start_now != '0 && r_stop_now == '0) begin
                        n_stop_now = r_column;
                    end
                end else if (r_in_run) begin
                    if (r_start_now == '0) begin
                        n_start_now = r_column;
                    end
                    n_in_run = 1'b0;
                end
            end
            if (last) begin
                n_start_prev = n_start_now;
                n_stop_prev  = n_stop_now;
                n_start_now  = '0;
                n_stop_now   = '0;
                n_in_run     = 1'b0;
                n_prev_valid = n_row_pixels;
                n_row_pixels = 1'b0;
                n_column     = '0;
            end else begin
                n_column = r_column + CW'(1);
            end
        end
    end

    always_comb begin
        n_out.out_valid      = r_s1_pv;
        n_out.out_end_of_row = r_s1_last;
        if (!r_s1_pv) begin
            n_out.out_red   = '0;
            n_out.out_green = '0;
            n_out.out_blue  = '0;
        end else if (r_s1_span) begin
            n_out.out_red   = cfg.lane_red;
            n_out.out_green = cfg.lane_green;
            n_out.out_blue  = cfg.lane_blue;
        end else begin
            n_out.out_red   = rd_pix[23:16];
            n_out.out_green = rd_pix[15:8];
            n_out.out_blue  = rd_pix[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_in_run     <= 1'b0;
            r_start_now  <= '0;
            r_stop_now   <= '0;
            r_start_prev <= '0;
            r_stop_prev  <= '0;
            r_prev_valid <= 1'b0;
            r_row_pixels <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_column     <= n_column;
            r_in_run     <= n_in_run;
            r_start_now  <= n_start_now;
            r_stop_now   <= n_stop_now;
            r_start_prev <= n_start_prev;
            r_stop_prev  <= n_stop_prev;
            r_prev_valid <= n_prev_valid;
            r_row_pixels <= n_row_pixels;
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pv   <= r_prev_valid;
            r_s1_span <= in_span;
            r_s1_last <= last;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input not ready with empty output register");

    a_invalid_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.out_valid) |->
        (o_out_data.out_red == '0 && o_out_data.out_green == '0
         && o_out_data.out_blue == '0))
        else $error("nonzero colour on beat without buffered row");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last) |=> (r_column == '0))
        else $error("column did not wrap at end of row");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("read stage lost a beat while stalled");

endmodule
